>>> sv/orbit_state_lagrange_interp_core_macros.svh
// Assertion helpers
`ifndef ORBIT_STATE_LAGRANGE_INTERP_CORE_MACROS_SVH
`define ORBIT_STATE_LAGRANGE_INTERP_CORE_MACROS_SVH
`define OSLI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define OSLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/osli_pkg.sv
package osli_pkg;
   localparam int MAX_VECTORS_DEF = 32;
   localparam int WINDOW_SIZE_DEF = 4;
   localparam int TW = 48;
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [62:0] WEIGHT_LIMIT = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] TERM_LIMIT = 63'h0800_0000_0000_0000;
   localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;
endpackage

>>> sv/osli_ram.sv
module osli_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/orbit_state_lagrange_interp_core.sv
// Orbit state vector table with cubic Lagrange interpolation.
// Request channel: pulse start with req_cmd and payload while busy is low.
//   clear (0) empties the table, append (1) stores one state vector,
//   query (2) interpolates position and velocity at req_time_value.
// Response channel: rsp_valid is high for one cycle with rsp_status and the
//   fields; the receiver must take it then, it cannot stall the block.
// Sequencing: clear and append go straight to the response state. A query walks
//   the epoch table one entry at a time, a read and then a compare, then computes
//   each window factor on one shared restoring divider (64 integer and 32
//   fraction steps, one bit a cycle) and one shared 32x32 multiplier used
//   over four partial products per Q32.32 product.
// busy is high from acceptance until the response and is low while rsp_valid is high; one request at a time.
// Reset clears the vector count and the sequencer; the tables hold stale data
//   that is never read before being written.
module orbit_state_lagrange_interp_core #(
   parameter int MAX_VECTORS = osli_pkg::MAX_VECTORS_DEF,
   parameter int WINDOW_SIZE = osli_pkg::WINDOW_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic signed [47:0] req_time_value,
   input  logic signed [47:0] req_in_pos_x,
   input  logic signed [47:0] req_in_pos_y,
   input  logic signed [47:0] req_in_pos_z,
   input  logic signed [47:0] req_in_vel_x,
   input  logic signed [47:0] req_in_vel_y,
   input  logic signed [47:0] req_in_vel_z,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic signed [47:0] rsp_epoch,
   output logic signed [47:0] rsp_pos_x,
   output logic signed [47:0] rsp_pos_y,
   output logic signed [47:0] rsp_pos_z,
   output logic signed [47:0] rsp_vel_x,
   output logic signed [47:0] rsp_vel_y,
   output logic signed [47:0] rsp_vel_z
);
`include "orbit_state_lagrange_interp_core_macros.svh"
   localparam int AW = $clog2(MAX_VECTORS);
   localparam int CW = $clog2(MAX_VECTORS + 1);
   localparam int WW = $clog2(WINDOW_SIZE + 1);
   localparam int IW = $clog2(WINDOW_SIZE);
   localparam int DW = 3 * 48;

   localparam logic [4:0] S_IDLE = 5'd0, S_RESP = 5'd1, S_SRCH = 5'd2,
      S_SRCHW = 5'd3, S_WIN = 5'd4, S_IRD = 5'd5, S_IRDW = 5'd6,
      S_JRD = 5'd7, S_JRDW = 5'd8, S_DIVQ = 5'd9, S_DIVF = 5'd10,
      S_MUL = 5'd11, S_VRD = 5'd12, S_VRDW = 5'd13, S_TERM = 5'd14,
      S_ONE = 5'd15, S_ONEW = 5'd16, S_FIN = 5'd17, S_MULW = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in, lo_ff, lo_in;
   logic [WW-1:0] used_ff, used_in;
   logic [IW-1:0] i_ff, i_in;
   logic [WW-1:0] j_ff, j_in;
   logic signed [47:0] t_ff, t_in, ti_ff, ti_in;
   logic [63:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0] step_ff, step_in;
   logic fneg_ff, fneg_in, wneg_ff, wneg_in;
   logic [62:0] w_ff, w_in, fm_ff, fm_in;
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [62:0] mlim_ff, mlim_in;
   logic [1:0] pp_ff, pp_in;
   logic [127:0] prod_ff, prod_in;
   logic [2:0] k_ff, k_in;
   logic signed [66:0] acc_ff [6];
   logic signed [66:0] acc_in [6];
   logic [1:0] rstat_ff, rstat_in;
   logic signed [47:0] rout_ff [7];
   logic signed [47:0] rout_in [7];
   logic rvalid_ff, rvalid_in;

   logic we;
   logic [AW-1:0] rd_addr;
   logic signed [47:0] ep_rd;
   logic [DW-1:0] pos_rd, vel_rd;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic signed [48:0] num_s, den_s;
   logic [64:0] rem_sh;
   logic [62:0] msat;
   logic [47:0] comp;
   logic cneg;

   assign we = (state_ff == S_IDLE) && start && (req_cmd == osli_pkg::CMD_APPEND)
      && (count_ff < CW'(MAX_VECTORS));

   osli_ram #(.WIDTH(48), .DEPTH(MAX_VECTORS)) u_ep (.clock(clock), .wr_en(we),
      .wr_addr(count_ff[AW-1:0]), .wr_data(req_time_value), .rd_addr(rd_addr),
      .rd_data(ep_rd));
   osli_ram #(.WIDTH(DW), .DEPTH(MAX_VECTORS)) u_pos (.clock(clock), .wr_en(we),
      .wr_addr(count_ff[AW-1:0]), .wr_data({req_in_pos_z, req_in_pos_y, req_in_pos_x}),
      .rd_addr(rd_addr), .rd_data(pos_rd));
   osli_ram #(.WIDTH(DW), .DEPTH(MAX_VECTORS)) u_vel (.clock(clock), .wr_en(we),
      .wr_addr(count_ff[AW-1:0]), .wr_data({req_in_vel_z, req_in_vel_y, req_in_vel_x}),
      .rd_addr(rd_addr), .rd_data(vel_rd));

   always_comb begin
      unique case (pp_ff)
         2'd0: begin mul_a = ma_ff[31:0];  mul_b = mb_ff[31:0];  end
         2'd1: begin mul_a = ma_ff[31:0];  mul_b = mb_ff[63:32]; end
         2'd2: begin mul_a = ma_ff[63:32]; mul_b = mb_ff[31:0];  end
         default: begin mul_a = ma_ff[63:32]; mul_b = mb_ff[63:32]; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (prod_ff[127:95] != '0) begin
         msat = mlim_ff;
      end else if (prod_ff[94:32] > mlim_ff) begin
         msat = mlim_ff;
      end else begin
         msat = prod_ff[94:32];
      end
   end

   always_comb begin
      unique case (k_ff)
         3'd0: comp = pos_rd[47:0];
         3'd1: comp = pos_rd[95:48];
         3'd2: comp = pos_rd[143:96];
         3'd3: comp = vel_rd[47:0];
         3'd4: comp = vel_rd[95:48];
         default: comp = vel_rd[143:96];
      endcase
   end

   assign num_s = 49'(t_ff) - 49'(ep_rd);
   assign den_s = 49'(ti_ff) - 49'(ep_rd);
   assign rem_sh = {rem_ff, 1'b0};
   assign cneg = comp[47];

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; lo_in = lo_ff;
      used_in = used_ff; i_in = i_ff; j_in = j_ff; t_in = t_ff; ti_in = ti_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      step_in = step_ff; fneg_in = fneg_ff; wneg_in = wneg_ff; w_in = w_ff;
      fm_in = fm_ff; ma_in = ma_ff; mb_in = mb_ff; mlim_in = mlim_ff; pp_in = pp_ff;
      prod_in = prod_ff; k_in = k_ff; rstat_in = rstat_ff; rvalid_in = 1'b0;
      rd_addr = idx_ff;
      for (int n = 0; n < 6; n++) acc_in[n] = acc_ff[n];
      for (int n = 0; n < 7; n++) rout_in[n] = rout_ff[n];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               t_in = req_time_value;
               rstat_in = osli_pkg::ST_OK;
               for (int n = 0; n < 7; n++) rout_in[n] = '0;
               state_in = S_RESP;
               if (req_cmd == osli_pkg::CMD_CLEAR) begin
                  count_in = '0;
               end else if (req_cmd == osli_pkg::CMD_APPEND) begin
                  if (we) count_in = count_ff + 1'b1;
                  else rstat_in = osli_pkg::ST_FULL;
               end else if (req_cmd == osli_pkg::CMD_QUERY) begin
                  if (count_ff == '0) begin
                     rstat_in = osli_pkg::ST_EMPTY;
                  end else if (count_ff == CW'(1)) begin
                     idx_in = '0;
                     state_in = S_ONE;
                  end else begin
                     idx_in = '0;
                     state_in = S_SRCH;
                  end
               end
            end
         end
         S_RESP: begin
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_ONE: begin
            rd_addr = '0;
            state_in = S_ONEW;
         end
         S_ONEW: begin
            rout_in[0] = ep_rd;
            rout_in[1] = pos_rd[47:0]; rout_in[2] = pos_rd[95:48];
            rout_in[3] = pos_rd[143:96];
            rout_in[4] = vel_rd[47:0]; rout_in[5] = vel_rd[95:48];
            rout_in[6] = vel_rd[143:96];
            state_in = S_RESP;
         end
         S_SRCH: begin
            if (CW'(idx_ff) + CW'(1) < count_ff) begin
               rd_addr = idx_ff + 1'b1;
               state_in = S_SRCHW;
            end else begin
               state_in = S_WIN;
            end
         end
         S_SRCHW: begin
            if (ep_rd <= t_ff) begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SRCH;
            end else begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            logic [AW-1:0] l;
            logic [CW-1:0] rem;
            l = (idx_ff != '0) ? idx_ff - 1'b1 : '0;
            rem = count_ff - CW'(l);
            used_in = (rem < CW'(WINDOW_SIZE)) ? WW'(rem) : WW'(WINDOW_SIZE);
            if (rem < CW'(2) && l != '0) begin
               l = l - 1'b1;
               used_in = WW'(2);
            end
            lo_in = l;
            i_in = '0;
            for (int n = 0; n < 6; n++) acc_in[n] = '0;
            state_in = S_IRD;
         end
         S_IRD: begin
            rd_addr = lo_ff + AW'(i_ff);
            state_in = S_IRDW;
         end
         S_IRDW: begin
            ti_in = ep_rd;
            w_in = 63'h1_0000_0000;
            wneg_in = 1'b0;
            j_in = '0;
            state_in = S_JRD;
         end
         S_JRD: begin
            if (WW'(j_ff) >= used_ff) begin
               k_in = '0;
               state_in = S_VRD;
            end else begin
               rd_addr = lo_ff + AW'(j_ff);
               state_in = S_JRDW;
            end
         end
         S_JRDW: begin
            if (j_ff == WW'(i_ff) || ep_rd == ti_ff) begin
               j_in = j_ff + 1'b1;
               state_in = S_JRD;
            end else begin
               num_in = num_s[48] ? 64'(-num_s) : 64'(num_s);
               den_in = den_s[48] ? 64'(-den_s) : 64'(den_s);
               fneg_in = num_s[48] ^ den_s[48];
               rem_in = '0;
               quo_in = '0;
               step_in = 7'd64;
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            logic [64:0] r;
            r = {rem_ff, num_ff[63]};
            num_in = {num_ff[62:0], 1'b0};
            if (r >= {1'b0, den_ff}) begin
               rem_in = 64'(r - {1'b0, den_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = r[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == 7'd1) begin
               step_in = 7'd32;
               state_in = S_DIVF;
            end
         end
         S_DIVF: begin
            logic fsat;
            fsat = (step_ff == 7'd32) && (quo_ff[63:31] != '0);
            if (fsat) begin
               fm_in = osli_pkg::WEIGHT_LIMIT;
               state_in = S_MUL;
            end else if (step_ff == '0) begin
               fm_in = 63'(quo_ff);
               state_in = S_MUL;
            end else begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = 64'(rem_sh - {1'b0, den_ff});
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rem_sh[63:0];
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               step_in = step_ff - 1'b1;
            end
            if (state_in == S_MUL) begin
               ma_in = {1'b0, w_ff};
               mb_in = {1'b0, fsat ? osli_pkg::WEIGHT_LIMIT : quo_ff[62:0]};
               mlim_in = osli_pkg::WEIGHT_LIMIT;
               pp_in = '0;
               prod_in = '0;
            end
         end
         S_MUL: begin
            unique case (pp_ff)
               2'd0: prod_in = prod_ff + 128'(mul_p);
               2'd1, 2'd2: prod_in = prod_ff + {32'd0, mul_p, 32'd0};
               default: prod_in = prod_ff + {mul_p, 64'd0};
            endcase
            pp_in = pp_ff + 1'b1;
            if (pp_ff == 2'd3) state_in = S_MULW;
         end
         S_MULW: begin
            if (mlim_ff == osli_pkg::WEIGHT_LIMIT) begin
               w_in = msat;
               wneg_in = wneg_ff ^ fneg_ff;
               j_in = j_ff + 1'b1;
               state_in = S_JRD;
            end else begin
               acc_in[k_ff] = (wneg_ff ^ fm_ff[0]) ? acc_ff[k_ff] - 67'(msat)
                  : acc_ff[k_ff] + 67'(msat);
               k_in = k_ff + 1'b1;
               state_in = (k_ff == 3'd5) ? S_TERM : S_VRD;
            end
         end
         S_VRD: begin
            rd_addr = lo_ff + AW'(i_ff);
            state_in = S_VRDW;
         end
         S_VRDW: begin
            rd_addr = lo_ff + AW'(i_ff);
            ma_in = {1'b0, w_ff};
            mb_in = cneg ? 64'(-{{16{comp[47]}}, comp}) : {16'd0, comp};
            fm_in = {62'd0, cneg};
            mlim_in = osli_pkg::TERM_LIMIT;
            pp_in = '0;
            prod_in = '0;
            state_in = S_MUL;
         end
         S_TERM: begin
            if (WW'(i_ff) + WW'(1) >= used_ff) begin
               state_in = S_FIN;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_IRD;
            end
         end
         S_FIN: begin
            rout_in[0] = t_ff;
            for (int n = 0; n < 6; n++) begin
               if (acc_ff[n] > 67'(osli_pkg::OUT_MAX)) rout_in[n+1] = osli_pkg::OUT_MAX[47:0];
               else if (acc_ff[n] < 67'(osli_pkg::OUT_MIN))
                  rout_in[n+1] = osli_pkg::OUT_MIN[47:0];
               else rout_in[n+1] = acc_ff[n][47:0];
            end
            state_in = S_RESP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
      end
      idx_ff <= idx_in; lo_ff <= lo_in; used_ff <= used_in; i_ff <= i_in; j_ff <= j_in;
      t_ff <= t_in; ti_ff <= ti_in; num_ff <= num_in; den_ff <= den_in;
      rem_ff <= rem_in; quo_ff <= quo_in; step_ff <= step_in; fneg_ff <= fneg_in;
      wneg_ff <= wneg_in; w_ff <= w_in; fm_ff <= fm_in; ma_ff <= ma_in; mb_ff <= mb_in;
      mlim_ff <= mlim_in; pp_ff <= pp_in; prod_ff <= prod_in; k_ff <= k_in;
      rstat_ff <= rstat_in;
      for (int n = 0; n < 6; n++) acc_ff[n] <= acc_in[n];
      for (int n = 0; n < 7; n++) rout_ff[n] <= rout_in[n];
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rvalid_ff;
   assign rsp_status = rstat_ff;
   assign rsp_epoch = rout_ff[0];
   assign rsp_pos_x = rout_ff[1];
   assign rsp_pos_y = rout_ff[2];
   assign rsp_pos_z = rout_ff[3];
   assign rsp_vel_x = rout_ff[4];
   assign rsp_vel_y = rout_ff[5];
   assign rsp_vel_z = rout_ff[6];

   `OSLI_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CW'(MAX_VECTORS), "count overflow")
   `OSLI_ASSERT_NEXT(a_resp_idle, clock, reset, state_ff == S_RESP, rsp_valid && !busy, "response lost")
   `OSLI_ASSERT_IMPL(a_full_flag, clock, reset, rsp_valid && rsp_status == osli_pkg::ST_FULL, count_ff == CW'(MAX_VECTORS), "full flag with room")
endmodule

>>> tb/sv/orbit_state_lagrange_interp_core_tb.sv
module orbit_state_lagrange_interp_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam int NUM_VECTORS = osli_pkg::MAX_VECTORS_DEF;
   localparam int WIN = osli_pkg::WINDOW_SIZE_DEF;
   localparam int ITEM_TARGET = 1200;
   localparam longint CYCLE_LIMIT = 6000000;
   localparam logic [63:0] WLIM = {1'b0, osli_pkg::WEIGHT_LIMIT};
   localparam logic [63:0] TLIM = {1'b0, osli_pkg::TERM_LIMIT};

   typedef struct packed {
      logic [1:0]       status;
      logic [47:0]      epoch;
      logic [5:0][47:0] comp;
   } orbit_result_type;

   logic clock, reset, start, busy, rsp_valid;
   logic [1:0] req_cmd, rsp_status;
   logic signed [47:0] req_time_value, req_in_pos_x, req_in_pos_y, req_in_pos_z;
   logic signed [47:0] req_in_vel_x, req_in_vel_y, req_in_vel_z;
   logic signed [47:0] rsp_epoch, rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [47:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;

   orbit_state_lagrange_interp_core dut (.*);

   longint epoch_store[NUM_VECTORS];
   longint pos_store[NUM_VECTORS][3];
   longint vel_store[NUM_VECTORS][3];
   int stored_count;
   orbit_result_type pending_results[$];
   int errors;
   int items_sent;
   longint cycles;
   bit no_idle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] magn(longint v);
      logic [63:0] m;
      m = v;
      return v < 0 ? -m : m;
   endfunction

   function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      logic [127:0] p;
      logic [63:0] s;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:95] != 0) return lim;
      s = p[95:32];
      return s > lim ? lim : s;
   endfunction

   function automatic longint signed_mul(longint a, longint b, logic [63:0] lim);
      logic [63:0] m;
      m = mul_q32(magn(a), magn(b), lim);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint factor_q32(longint num, longint den);
      logic [63:0] un, ud, q, r, f, m;
      un = magn(num);
      ud = magn(den);
      q = un / ud;
      if (q >= 64'h8000_0000) begin
         m = WLIM;
      end else begin
         r = un % ud;
         f = 0;
         for (int i = 0; i < 32; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= ud) begin
               r = r - ud;
               f[0] = 1'b1;
            end
         end
         m = (q << 32) | f;
      end
      return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [47:0] clamp48(longint v);
      if (v > osli_pkg::OUT_MAX) v = osli_pkg::OUT_MAX;
      if (v < osli_pkg::OUT_MIN) v = osli_pkg::OUT_MIN;
      return v[47:0];
   endfunction

   function automatic orbit_result_type interpolate(longint t);
      orbit_result_type res;
      int idx, lo, used;
      longint w, ti, tj;
      longint acc[6];
      res = '0;
      if (stored_count == 1) begin
         res.epoch = epoch_store[0][47:0];
         for (int k = 0; k < 3; k++) begin
            res.comp[k] = pos_store[0][k][47:0];
            res.comp[3+k] = vel_store[0][k][47:0];
         end
         return res;
      end
      for (int k = 0; k < 6; k++) acc[k] = 0;
      idx = 0;
      while (idx + 1 < stored_count && epoch_store[idx+1] <= t) idx++;
      lo = idx >= 1 ? idx - 1 : 0;
      used = stored_count - lo < WIN ? stored_count - lo : WIN;
      if (used < 2 && lo > 0) begin
         lo--;
         used = 2;
      end
      for (int i = 0; i < used; i++) begin
         w = 64'sh1_0000_0000;
         ti = epoch_store[lo+i];
         for (int j = 0; j < used; j++) begin
            tj = epoch_store[lo+j];
            if (i != j && ti != tj) w = signed_mul(w, factor_q32(t - tj, ti - tj), WLIM);
         end
         for (int k = 0; k < 3; k++) begin
            acc[k] += signed_mul(w, pos_store[lo+i][k], TLIM);
            acc[3+k] += signed_mul(w, vel_store[lo+i][k], TLIM);
         end
      end
      res.epoch = t[47:0];
      for (int k = 0; k < 6; k++) res.comp[k] = clamp48(acc[k]);
      return res;
   endfunction

   function automatic orbit_result_type apply_request(logic [1:0] cmd, logic [47:0] tv,
                                                      logic [2:0][47:0] p, logic [2:0][47:0] v);
      orbit_result_type res;
      longint t;
      res = '0;
      t = longint'(signed'(tv));
      if (cmd == osli_pkg::CMD_CLEAR) begin
         stored_count = 0;
      end else if (cmd == osli_pkg::CMD_APPEND) begin
         if (stored_count >= NUM_VECTORS) begin
            res.status = osli_pkg::ST_FULL;
         end else begin
            epoch_store[stored_count] = t;
            for (int k = 0; k < 3; k++) begin
               pos_store[stored_count][k] = longint'(signed'(p[k]));
               vel_store[stored_count][k] = longint'(signed'(v[k]));
            end
            stored_count++;
         end
      end else if (cmd == osli_pkg::CMD_QUERY) begin
         if (stored_count == 0) res.status = osli_pkg::ST_EMPTY;
         else res = interpolate(t);
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return r[47:0];
         1: return {{24{r[23]}}, r[23:0]};
         2: return {{12{r[35]}}, r[35:0]};
         3: return {{8{r[39]}}, r[39:0]};
         default: begin
            case ($urandom_range(0, 3))
               0: return 48'h7FFF_FFFF_FFFF;
               1: return 48'h8000_0000_0000;
               2: return 48'h0;
               default: return 48'hFFFF_FFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic send_request(logic [1:0] cmd, logic [47:0] tv,
                               logic [2:0][47:0] p, logic [2:0][47:0] v);
      int gap;
      start <= 1'b1;
      req_cmd <= cmd;
      req_time_value <= tv;
      req_in_pos_x <= p[0];
      req_in_pos_y <= p[1];
      req_in_pos_z <= p[2];
      req_in_vel_x <= v[0];
      req_in_vel_y <= v[1];
      req_in_vel_z <= v[2];
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_request(cmd, tv, p, v));
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic append_random(logic [47:0] tv);
      logic [2:0][47:0] p, v;
      for (int k = 0; k < 3; k++) begin
         p[k] = rand48();
         v[k] = rand48();
      end
      send_request(osli_pkg::CMD_APPEND, tv, p, v);
   endtask

   task automatic simple_request(logic [1:0] cmd, logic [47:0] tv);
      send_request(cmd, tv, '0, '0);
   endtask

   task automatic test_directed();
      logic [2:0][47:0] pmax, pmin;
      pmax = {3{48'h7FFF_FFFF_FFFF}};
      pmin = {3{48'h8000_0000_0000}};
      simple_request(osli_pkg::CMD_QUERY, 48'h0);
      simple_request(CMD_NOP, 48'h7FFF_FFFF_FFFF);
      send_request(osli_pkg::CMD_APPEND, 48'h0000_4000_0000, pmax, pmin);
      simple_request(osli_pkg::CMD_QUERY, 48'h8000_0000_0000);
      simple_request(osli_pkg::CMD_QUERY, 48'h7FFF_FFFF_FFFF);
      send_request(osli_pkg::CMD_APPEND, 48'h0000_4000_0000, pmin, pmax);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_4000_0000);
      send_request(osli_pkg::CMD_APPEND, 48'h0000_8000_0000, pmax, pmax);
      send_request(osli_pkg::CMD_APPEND, 48'h0000_C000_0000, pmin, pmin);
      append_random(48'h0001_0000_0000);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_6000_0000);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_A123_4567);
      simple_request(osli_pkg::CMD_QUERY, 48'h8000_0000_0000);
      simple_request(osli_pkg::CMD_QUERY, 48'h7FFF_FFFF_FFFF);
      append_random(48'h0000_2000_0000);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_E000_0000);
      simple_request(osli_pkg::CMD_CLEAR, 48'hFFFF_FFFF_FFFF);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_1000_0000);
      send_request(osli_pkg::CMD_APPEND, 48'h8000_0000_0000, '0, pmax);
      send_request(osli_pkg::CMD_APPEND, 48'h7FFF_FFFF_FFFF, pmin, '0);
      simple_request(osli_pkg::CMD_QUERY, 48'h0);
      simple_request(osli_pkg::CMD_CLEAR, 48'h0);
   endtask

   task automatic test_full_table();
      logic [47:0] ep;
      no_idle = 1'b1;
      ep = 48'h0000_0100_0000;
      for (int i = 0; i < NUM_VECTORS + 2; i++) begin
         append_random(ep);
         ep = ep + $urandom_range(1, 1 << 28);
      end
      no_idle = 1'b0;
      simple_request(osli_pkg::CMD_QUERY, ep);
      simple_request(osli_pkg::CMD_QUERY, 48'h0000_0180_0000);
      simple_request(osli_pkg::CMD_CLEAR, 48'h0);
   endtask

   task automatic test_random();
      longint ep, t;
      longint eps[$];
      int n, nq;
      logic [63:0] r;
      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 5) == 0);
         simple_request(osli_pkg::CMD_CLEAR, rand48());
         eps.delete();
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, NUM_VECTORS)
                                         : $urandom_range(1, 6);
         r = {$urandom, $urandom};
         ep = longint'(signed'(r[39:0]));
         for (int i = 0; i < n; i++) begin
            append_random(ep[47:0]);
            eps.push_back(ep);
            case ($urandom_range(0, 11))
               0: ep = ep;
               1: ep = ep - $urandom_range(1, 1 << 26);
               default: ep = ep + $urandom_range(1, 1 << 30);
            endcase
         end
         nq = $urandom_range(1, 4);
         for (int q = 0; q < nq; q++) begin
            r = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: t = longint'(signed'(rand48()));
               1: t = eps[0] - $urandom_range(0, 1 << 30);
               2: t = eps[eps.size()-1] + $urandom_range(0, 1 << 30);
               default: t = eps[$urandom_range(0, eps.size() - 1)]
                            + $urandom_range(0, 1 << 30) - (1 << 29);
            endcase
            simple_request(osli_pkg::CMD_QUERY, t[47:0]);
         end
         if ($urandom_range(0, 3) == 0) begin
            r = {$urandom, $urandom};
            case ($urandom_range(0, 2))
               0: send_request(CMD_NOP, rand48(), {rand48(), rand48(), rand48()},
                               {rand48(), rand48(), rand48()});
               1: append_random(rand48());
               default: simple_request(osli_pkg::CMD_QUERY, rand48());
            endcase
         end
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      orbit_result_type got, want;
      got = {rsp_status, rsp_epoch, rsp_vel_z, rsp_vel_y, rsp_vel_x,
             rsp_pos_z, rsp_pos_y, rsp_pos_x};
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %h actual %h", $time, want.status, got.status);
               errors++;
            end
            if (got.epoch !== want.epoch) begin
               $display("%0t: epoch expected %h actual %h", $time, want.epoch, got.epoch);
               errors++;
            end
            for (int k = 0; k < 6; k++) begin
               if (got.comp[k] !== want.comp[k]) begin
                  $display("%0t: component %0d expected %h actual %h",
                           $time, k, want.comp[k], got.comp[k]);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cmd = osli_pkg::CMD_CLEAR;
      req_time_value = '0;
      req_in_pos_x = '0;
      req_in_pos_y = '0;
      req_in_pos_z = '0;
      req_in_vel_x = '0;
      req_in_vel_y = '0;
      req_in_vel_z = '0;
      cycles = 0;
      errors = 0;
      items_sent = 0;
      stored_count = 0;
      no_idle = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
